// ===== hw/rtl/hdtl_pkg.sv =====
// Shared types and constants for the heredoc token lexer.
// No dependencies; imported by every module of the block.
package hdtl_pkg;

   localparam int CHAR_W = 16;

   // character codes
   localparam logic [CHAR_W-1:0] CH_EOS    = 16'hEE0F;
   localparam logic [CHAR_W-1:0] CH_DQUOTE = 16'h0022;
   localparam logic [CHAR_W-1:0] CH_POUND  = 16'h0023;
   localparam logic [CHAR_W-1:0] CH_EQUAL  = 16'h003D;
   localparam logic [CHAR_W-1:0] CH_SEMI   = 16'h003B;
   localparam logic [CHAR_W-1:0] CH_SQUOTE = 16'h0027;
   localparam logic [CHAR_W-1:0] CH_STAR   = 16'h002A;
   localparam logic [CHAR_W-1:0] CH_SLASH  = 16'h002F;
   localparam logic [CHAR_W-1:0] CH_SPACE  = 16'h0020;
   localparam logic [CHAR_W-1:0] CH_TAB    = 16'h0009;
   localparam logic [CHAR_W-1:0] CH_LF     = 16'h000A;
   localparam logic [CHAR_W-1:0] CH_FF     = 16'h000C;
   localparam logic [CHAR_W-1:0] CH_NUL    = 16'h0000;

   // token kinds
   localparam logic [3:0] K_IDCHAR  = 4'd0;
   localparam logic [3:0] K_IDEND   = 4'd1;
   localparam logic [3:0] K_QUOTE   = 4'd2;
   localparam logic [3:0] K_CONNECT = 4'd3;
   localparam logic [3:0] K_STMTEND = 4'd4;
   localparam logic [3:0] K_ROUTEND = 4'd5;
   localparam logic [3:0] K_DELIM   = 4'd6;
   localparam logic [3:0] K_TEXT    = 4'd7;
   localparam logic [3:0] K_TEXTEND = 4'd8;
   localparam logic [3:0] K_ERROR   = 4'd9;

   // error codes
   localparam logic [2:0] E_UNKNOWN_CTRL = 3'd0;
   localparam logic [2:0] E_EOF_CTRL     = 3'd1;
   localparam logic [2:0] E_EOF_COMMENT  = 3'd2;
   localparam logic [2:0] E_EOF_TEXT     = 3'd3;
   localparam logic [2:0] E_DELIM_LONG   = 3'd4;

   // broadcast from the lexer control to every window cell
   typedef struct packed {
      logic              delim_wr;
      logic              win_fill;
      logic              win_shift;
      logic [CHAR_W-1:0] chr;
   } cell_ctl_type;

   // one result transaction
   typedef struct packed {
      logic              last;
      logic [2:0]        err;
      logic [CHAR_W-1:0] chr;
      logic [3:0]        kind;
   } result_type;

endpackage

// ===== hw/rtl/hdtl_cell.sv =====
// One window cell: holds a delimiter character and a text window slot.
// Depends on hdtl_pkg; chained by the top level, window shifts toward cell 0.
module hdtl_cell #(
   parameter int LEN_W = 5,
   parameter int INDEX = 0
) (
   input  logic                      clock,
   input  hdtl_pkg::cell_ctl_type    ctl,
   input  logic [LEN_W-1:0]          delim_length,
   input  logic [LEN_W-1:0]          window_fill,
   input  logic [hdtl_pkg::CHAR_W-1:0] next_in,
   output logic [hdtl_pkg::CHAR_W-1:0] win_out,
   output logic                      match
);
   import hdtl_pkg::*;

   logic [CHAR_W-1:0] delim_ff;
   logic [CHAR_W-1:0] win_ff;
   logic [CHAR_W-1:0] win_in;

   localparam logic [LEN_W-1:0] MY_IDX  = LEN_W'(INDEX);
   localparam logic [LEN_W-1:0] MY_NEXT = LEN_W'(INDEX + 1);

   always_comb begin
      win_in = win_ff;
      if (ctl.win_fill && window_fill == MY_IDX) begin
         win_in = ctl.chr;
      end else if (ctl.win_shift) begin
         if (MY_NEXT == delim_length) begin
            win_in = ctl.chr;
         end else if (MY_NEXT < delim_length) begin
            win_in = next_in;
         end
      end
   end

   // slots past the delimiter length never take part in the compare
   assign match   = (MY_IDX >= delim_length) || (win_in == delim_ff);
   assign win_out = win_ff;

   always_ff @(posedge clock) begin
      win_ff <= win_in;
      if (ctl.delim_wr && delim_length == MY_IDX) begin
         delim_ff <= ctl.chr;
      end
   end
endmodule

// ===== hw/rtl/hdtl_result_fifo.sv =====
// Four-entry result queue between the lexer and the result channel.
// Needs hdtl_pkg; takes up to two results, gives one per ready cycle.
module hdtl_result_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [1:0]            push_count,
   input  hdtl_pkg::result_type  push_data [2],
   output logic                  room,
   output logic                  out_valid,
   input  logic                  out_ready,
   output hdtl_pkg::result_type  out_data
);
   import hdtl_pkg::*;

   result_type entry_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic       pop;

   assign room      = (count_ff <= 3'd2);
   assign out_valid = (count_ff != 3'd0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + push_count;
      rd_ptr_in = rd_ptr_ff + {1'b0, pop};
      count_in  = count_ff + {1'b0, push_count} - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push_count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push_data[0];
      end
      if (push_count == 2'd2) begin
         entry_ff[wr_ptr_ff + 2'd1] <= push_data[1];
      end
   end
endmodule

// ===== hw/rtl/heredoc_token_lexer.sv =====
// Top level of the heredoc token lexer: lexer control, window cell chain, result queue.
// Depends on hdtl_pkg, hdtl_cell and hdtl_result_fifo.
//
//   channel  | dir | data                                   | side info
//   ---------+-----+----------------------------------------+-----------------------
//   req_     | in  | tdata[15:0] char_code                  | tuser[0] opcode
//   rsp_     | out | tdata[3:0] kind, [19:4] char, [22:20]  | tlast = last result
//            |     | error code, [23] zero                  |   of one request
//
// One request transaction per cycle while req_tready is high: the lexer state, the
// delimiter compare over the cell chain and the result generation all settle within
// the accepting cycle. A request gives zero, one or two results; the result queue
// drains one per cycle while rsp_tready is high, so a run of two-result requests is
// paced by the rsp_ side at one result per cycle. req_tready drops only while the
// queue holds more than two results. Results leave in order from the queue registers.
// reset (synchronous) clears lexer control and the queue; delimiter and window
// storage in the cells is left as is and only read once written.
module heredoc_token_lexer #(
   parameter int DELIM_MAX = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] char_code
   input  logic [0:0]  req_tuser,   // [0] opcode: 0 lex, 1 restart
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [3:0] token_kind, [19:4] char_out, [22:20] error_code
   output logic        rsp_tlast    // last result of the request
);
   import hdtl_pkg::*;

   localparam int LEN_W = $clog2(DELIM_MAX + 1);
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(DELIM_MAX);

   typedef enum logic [2:0] {
      M_BEGIN, M_CONTROL, M_IDENT, M_BLOCK, M_LINE, M_TEXT, M_ERROR, M_ENDED
   } mode_type;

   typedef struct packed {
      mode_type   mode;
      logic       hit;
      logic [3:0] kind;
      logic       text;
   } start_type;

   // begin-state decode of one character
   function automatic start_type start_fn(input logic [CHAR_W-1:0] c);
      start_type s;
      s.mode = M_BEGIN;
      s.hit  = 1'b0;
      s.kind = K_IDCHAR;
      s.text = 1'b0;
      unique case (c)
         CH_SPACE, CH_TAB, CH_LF, CH_FF, CH_NUL: ;
         CH_SQUOTE: begin
            s.hit  = 1'b1;
            s.kind = K_QUOTE;
         end
         CH_DQUOTE: begin
            s.mode = M_TEXT;
            s.text = 1'b1;
         end
         CH_EQUAL: begin
            s.hit  = 1'b1;
            s.kind = K_CONNECT;
         end
         CH_SEMI: begin
            s.hit  = 1'b1;
            s.kind = K_STMTEND;
         end
         CH_POUND: s.mode = M_CONTROL;
         CH_EOS:   s.mode = M_ENDED;
         default: begin
            s.mode = M_IDENT;
            s.hit  = 1'b1;
            s.kind = K_IDCHAR;
         end
      endcase
      return s;
   endfunction

   mode_type         mode_ff, mode_in;
   logic             pound_ff, pound_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic             complete_ff, complete_in;
   logic [LEN_W-1:0] fill_ff, fill_in;

   logic              accept;
   logic [CHAR_W-1:0] c;
   start_type         start;
   cell_ctl_type      cell_ctl;
   logic              check;
   logic [1:0]        res_cnt;
   result_type        res [2];
   logic [1:0]        push_count;
   result_type        out_data;

   logic [CHAR_W-1:0]    win_out   [DELIM_MAX];
   logic [DELIM_MAX-1:0] match_vec;
   logic                 match_all;

   assign accept    = req_tvalid && req_tready;
   assign c         = req_tdata;
   assign start     = start_fn(c);
   assign match_all = &match_vec;

   // Lexer control. Results are collected in order into res[0], res[1].
   always_comb begin
      mode_in     = mode_ff;
      pound_in    = pound_ff;
      len_in      = len_ff;
      complete_in = complete_ff;
      fill_in     = fill_ff;
      cell_ctl    = '{delim_wr: 1'b0, win_fill: 1'b0, win_shift: 1'b0, chr: c};
      check       = 1'b0;
      res_cnt     = 2'd0;
      res[0]      = '0;
      res[1]      = '0;

      if (req_tuser[0]) begin
         // restart: back to reset values, no result
         mode_in     = M_BEGIN;
         pound_in    = 1'b0;
         len_in      = '0;
         complete_in = 1'b0;
         fill_in     = '0;
      end else begin
         unique case (mode_ff)
            M_BEGIN, M_IDENT: begin
               if (mode_ff == M_IDENT && !(start.hit && start.kind == K_IDCHAR)) begin
                  // terminator: close the identifier, then lex c from begin
                  res[res_cnt[0]].kind = K_IDEND;
                  res_cnt = res_cnt + 2'd1;
               end
               mode_in = start.mode;
               if (start.hit) begin
                  res[res_cnt[0]].kind = start.kind;
                  if (start.kind == K_IDCHAR) begin
                     res[res_cnt[0]].chr = c;
                  end
                  res_cnt = res_cnt + 2'd1;
               end
               if (start.text) begin
                  len_in      = '0;
                  complete_in = 1'b0;
                  fill_in     = '0;
               end
            end
            M_CONTROL: begin
               priority if (c == CH_EOS) begin
                  mode_in = M_ERROR;
                  res[0].kind = K_ERROR;
                  res[0].err  = E_EOF_CTRL;
                  res_cnt = 2'd1;
               end else if (c == CH_STAR) begin
                  mode_in  = M_BLOCK;
                  pound_in = 1'b0;
               end else if (c == CH_SLASH) begin
                  mode_in = M_LINE;
               end else if (c == CH_SEMI) begin
                  mode_in = M_BEGIN;
                  res[0].kind = K_ROUTEND;
                  res_cnt = 2'd1;
               end else begin
                  mode_in = M_ERROR;
                  res[0].kind = K_ERROR;
                  res[0].err  = E_UNKNOWN_CTRL;
                  res_cnt = 2'd1;
               end
            end
            M_BLOCK: begin
               priority if (c == CH_EOS) begin
                  mode_in = M_ERROR;
                  res[0].kind = K_ERROR;
                  res[0].err  = E_EOF_COMMENT;
                  res_cnt = 2'd1;
               end else if (pound_ff) begin
                  // a run of pounds keeps the close armed
                  if (c == CH_STAR) begin
                     mode_in = M_BEGIN;
                  end else if (c != CH_POUND) begin
                     pound_in = 1'b0;
                  end
               end else if (c == CH_POUND) begin
                  pound_in = 1'b1;
               end else begin
                  pound_in = 1'b0;
               end
            end
            M_LINE: begin
               if (c == CH_LF || c == CH_FF) begin
                  mode_in = M_BEGIN;
               end else if (c == CH_EOS) begin
                  mode_in = M_ENDED;
               end
            end
            M_TEXT: begin
               priority if (c == CH_EOS) begin
                  mode_in = M_ERROR;
                  res[0].kind = K_ERROR;
                  res[0].err  = E_EOF_TEXT;
                  res_cnt = 2'd1;
               end else if (!complete_ff) begin
                  if (c != CH_DQUOTE) begin
                     if (len_ff >= LEN_MAX) begin
                        mode_in = M_ERROR;
                        res[0].kind = K_ERROR;
                        res[0].err  = E_DELIM_LONG;
                        res_cnt = 2'd1;
                     end else begin
                        cell_ctl.delim_wr = 1'b1;
                        len_in = len_ff + LEN_W'(1);
                        res[0].kind = K_DELIM;
                        res[0].chr  = c;
                        res_cnt = 2'd1;
                     end
                  end else begin
                     // closing quote of the delimiter; empty delimiter ends at once
                     complete_in = 1'b1;
                     fill_in     = '0;
                     check       = 1'b1;
                  end
               end else if (fill_ff >= len_ff) begin
                  // window full: oldest character leaves, c enters at the tail
                  cell_ctl.win_shift = 1'b1;
                  res[0].kind = K_TEXT;
                  res[0].chr  = win_out[0];
                  res_cnt = 2'd1;
                  check   = 1'b1;
               end else begin
                  cell_ctl.win_fill = 1'b1;
                  fill_in = fill_ff + LEN_W'(1);
                  check   = 1'b1;
               end
               if (check && fill_in == len_ff && match_all) begin
                  res[res_cnt[0]].kind = K_TEXTEND;
                  res_cnt = res_cnt + 2'd1;
                  mode_in = M_BEGIN;
               end
            end
            M_ERROR, M_ENDED: ;
            default: ;
         endcase
      end

      if (res_cnt == 2'd1) begin
         res[0].last = 1'b1;
      end else if (res_cnt == 2'd2) begin
         res[1].last = 1'b1;
      end

      if (!accept) begin
         cell_ctl.delim_wr  = 1'b0;
         cell_ctl.win_fill  = 1'b0;
         cell_ctl.win_shift = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= M_BEGIN;
         pound_ff    <= 1'b0;
         len_ff      <= '0;
         complete_ff <= 1'b0;
         fill_ff     <= '0;
      end else if (accept) begin
         mode_ff     <= mode_in;
         pound_ff    <= pound_in;
         len_ff      <= len_in;
         complete_ff <= complete_in;
         fill_ff     <= fill_in;
      end
   end

   // Window cell chain: cell i takes cell i+1's slot on a shift.
   for (genvar i = 0; i < DELIM_MAX; i++) begin : g_cell
      logic [CHAR_W-1:0] neighbor;
      if (i == DELIM_MAX - 1) begin : g_tail
         assign neighbor = '0;
      end else begin : g_mid
         assign neighbor = win_out[i+1];
      end
      hdtl_cell #(
         .LEN_W (LEN_W),
         .INDEX (i)
      ) u_cell (
         .clock        (clock),
         .ctl          (cell_ctl),
         .delim_length (len_ff),
         .window_fill  (fill_ff),
         .next_in      (neighbor),
         .win_out      (win_out[i]),
         .match        (match_vec[i])
      );
   end

   assign push_count = accept ? res_cnt : 2'd0;

   hdtl_result_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push_data  (res),
      .room       (req_tready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_data   (out_data)
   );

   assign rsp_tdata = {1'b0, out_data.err, out_data.chr, out_data.kind};
   assign rsp_tlast = out_data.last;

   // a restart always lands in the begin state
   a_restart: assert property (@(posedge clock) disable iff (reset)
      accept && req_tuser[0] |=> mode_ff == M_BEGIN)
      else $error("restart did not return to begin");

   // the window never holds more than the delimiter
   a_fill: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= len_ff)
      else $error("window fill exceeds delimiter length");

   a_len: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_MAX)
      else $error("delimiter length exceeds maximum");

   // errors stick until a restart
   a_sticky: assert property (@(posedge clock) disable iff (reset)
      mode_ff == M_ERROR && !(accept && req_tuser[0]) |=> mode_ff == M_ERROR)
      else $error("error state left without restart");

endmodule

// ===== dv/heredoc_token_lexer_test.sv =====
// Self-checking testbench for heredoc_token_lexer: a scoreboard class predicts every token
// from the accepted characters. Depends on hdtl_pkg and the heredoc_token_lexer RTL only.
module heredoc_token_lexer_test;
   timeunit 1ns;
   timeprecision 1ps;

   import hdtl_pkg::*;

   localparam int DELIM_MAX   = 16;
   localparam int CYCLE_LIMIT = 200000;   // far above the slowest legal run
   localparam int SETTLE      = 16;       // results leave through the registered result queue

   localparam logic OP_LEX     = 1'b0;
   localparam logic OP_RESTART = 1'b1;

   // one result transaction as seen on rsp_
   typedef struct packed {
      logic [3:0]  kind;
      logic [15:0] chr;
      logic [2:0]  err;
      logic        last;
   } token_type;

   // ------------------------------------------------------------------------
   // Scoreboard: its own copy of the lexer state, a queue of pending tokens
   // ------------------------------------------------------------------------
   class lexer_scoreboard;
      typedef enum logic [2:0] {
         LX_BEGIN, LX_CONTROL, LX_IDENT, LX_BLOCK, LX_LINE, LX_TEXT, LX_ERROR, LX_ENDED
      } lex_mode_type;

      lex_mode_type mode;
      bit          pound_seen;
      logic [15:0] delim_chars [DELIM_MAX];
      int          delim_len;
      bit          delim_done;
      logic [15:0] window [DELIM_MAX];
      int          win_fill;
      logic [2:0]  sticky_code;

      token_type   step_tokens[$];       // tokens of the transaction being lexed
      token_type   expected_tokens[$];   // tokens still owed by the block

      int mismatches, tokens_checked, lexed_chars, restarts, error_tokens, text_ends;

      function new();
         clear_state();
      endfunction

      function void clear_state();
         mode        = LX_BEGIN;
         pound_seen  = 0;
         delim_len   = 0;
         delim_done  = 0;
         win_fill    = 0;
         sticky_code = '0;
      endfunction

      static function bit ends_identifier(logic [15:0] c);
         case (c)
            CH_SPACE, CH_TAB, CH_LF, CH_FF, CH_NUL,
            CH_SEMI, CH_SQUOTE, CH_DQUOTE, CH_EQUAL, CH_POUND, CH_EOS: return 1;
            default: return 0;
         endcase
      endfunction

      // true while characters are swallowed until a restart
      function bit halted();
         return mode == LX_ERROR || mode == LX_ENDED;
      endfunction

      function void emit(logic [3:0] kind, logic [15:0] chr, logic [2:0] err);
         token_type t;
         if (step_tokens.size() >= 2) return;
         t.kind = kind;
         t.chr  = chr;
         t.err  = err;
         t.last = 0;
         step_tokens = {step_tokens, t};
      endfunction

      function void raise_error(logic [2:0] code);
         mode        = LX_ERROR;
         sticky_code = code;
         emit(K_ERROR, '0, code);
      endfunction

      function void start_token(logic [15:0] c);
         case (c)
            CH_SPACE, CH_TAB, CH_LF, CH_FF, CH_NUL: ;
            CH_SQUOTE: emit(K_QUOTE, '0, '0);
            CH_DQUOTE: begin
               mode       = LX_TEXT;
               delim_len  = 0;
               delim_done = 0;
               win_fill   = 0;
            end
            CH_EQUAL: emit(K_CONNECT, '0, '0);
            CH_SEMI:  emit(K_STMTEND, '0, '0);
            CH_POUND: mode = LX_CONTROL;
            CH_EOS:   mode = LX_ENDED;
            default: begin
               mode = LX_IDENT;
               emit(K_IDCHAR, c, '0);
            end
         endcase
      endfunction

      function bit window_matches();
         for (int i = 0; i < delim_len; i++)
            if (window[i] != delim_chars[i]) return 0;
         return 1;
      endfunction

      function void text_char(logic [15:0] c);
         if (c == CH_EOS) begin
            raise_error(E_EOF_TEXT);
            return;
         end
         if (!delim_done) begin
            if (c != CH_DQUOTE) begin
               if (delim_len >= DELIM_MAX) begin
                  raise_error(E_DELIM_LONG);
                  return;
               end
               delim_chars[delim_len] = c;
               delim_len++;
               emit(K_DELIM, c, '0);
               return;
            end
            delim_done = 1;
            win_fill   = 0;
         end else if (win_fill >= delim_len) begin
            if (delim_len == 0) begin
               emit(K_TEXT, c, '0);
            end else begin
               // oldest character leaves the delay window
               emit(K_TEXT, window[0], '0);
               for (int i = 0; i < delim_len - 1; i++) window[i] = window[i+1];
               window[delim_len-1] = c;
            end
         end else begin
            window[win_fill] = c;
            win_fill++;
         end
         // compare only with a full window
         if (win_fill == delim_len && window_matches()) begin
            emit(K_TEXTEND, '0, '0);
            mode = LX_BEGIN;
         end
      endfunction

      function void lex_char(logic [15:0] c);
         case (mode)
            LX_BEGIN: start_token(c);
            LX_CONTROL: begin
               if (c == CH_EOS) raise_error(E_EOF_CTRL);
               else if (c == CH_STAR) begin
                  mode       = LX_BLOCK;
                  pound_seen = 0;
               end else if (c == CH_SLASH) mode = LX_LINE;
               else if (c == CH_SEMI) begin
                  emit(K_ROUTEND, '0, '0);
                  mode = LX_BEGIN;
               end else raise_error(E_UNKNOWN_CTRL);
            end
            LX_IDENT: begin
               if (ends_identifier(c)) begin
                  emit(K_IDEND, '0, '0);
                  mode = LX_BEGIN;
                  start_token(c);
               end else emit(K_IDCHAR, c, '0);
            end
            LX_BLOCK: begin
               if (c == CH_EOS) raise_error(E_EOF_COMMENT);
               else if (pound_seen) begin
                  if (c == CH_STAR) mode = LX_BEGIN;
                  else if (c != CH_POUND) pound_seen = 0;
               end else if (c == CH_POUND) pound_seen = 1;
            end
            LX_LINE: begin
               if (c == CH_LF || c == CH_FF) mode = LX_BEGIN;
               else if (c == CH_EOS) mode = LX_ENDED;
            end
            LX_TEXT: text_char(c);
            default: ;
         endcase
      endfunction

      // accepted request transaction: predict its tokens
      function void lex_request(logic op, logic [15:0] c);
         step_tokens.delete();
         if (op == OP_RESTART) begin
            clear_state();
            restarts++;
            return;
         end
         if (!halted()) lexed_chars++;
         lex_char(c);
         if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last = 1;
         expected_tokens = {expected_tokens, step_tokens};
      endfunction

      // accepted result transaction: compare with the oldest pending token
      function void match_token(logic [23:0] data, logic tlast);
         token_type got, want;
         got.kind = data[3:0];
         got.chr  = data[19:4];
         got.err  = data[22:20];
         got.last = tlast;
         if (expected_tokens.size() == 0) begin
            $display("%0t: unexpected token kind %0d char %h err %0d last %b",
                     $time, got.kind, got.chr, got.err, got.last);
            mismatches++;
            return;
         end
         want = expected_tokens.pop_front();
         tokens_checked++;
         if (want.kind == K_ERROR) error_tokens++;
         if (want.kind == K_TEXTEND) text_ends++;
         if (got !== want || data[23] !== 1'b0) begin
            $display("%0t: token mismatch, expected kind %0d char %h err %0d last %b",
                     $time, want.kind, want.chr, want.err, want.last);
            $display("%0t:                 got kind %0d char %h err %0d last %b pad %b",
                     $time, got.kind, got.chr, got.err, got.last, data[23]);
            mismatches++;
         end
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // Clock, reset, DUT
   // ------------------------------------------------------------------------
   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic [0:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;

   always #2 clock = ~clock;

   heredoc_token_lexer #(.DELIM_MAX(DELIM_MAX)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   lexer_scoreboard sb = new();

   int src_idle  = 14;    // percent of cycles the character source holds back
   int sink_idle = 59;    // percent of cycles the token sink stalls
   int requests_taken;    // bumped at every accepted request transaction
   int cycles;

   // Monitor: both channels sampled at the rising edge, inputs move at the falling edge,
   // so nothing here races the DUT's own register updates.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            sb.lex_request(req_tuser[0], req_tdata);
            requests_taken++;
         end
         if (rsp_tvalid && rsp_tready) sb.match_token(rsp_tdata, rsp_tlast);
      end
   end

   // Sink back-pressure, re-rolled every cycle.
   always @(negedge clock) rsp_tready <= ($urandom_range(99) >= sink_idle);

   // Watchdog.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d tokens still pending",
                  $time, cycles, sb.expected_tokens.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Driver tasks: always entered and left at a falling edge
   // ------------------------------------------------------------------------

   // Present one request transaction and hold it until the monitor saw it accepted.
   // Each falling edge gets at most one assignment to req_tvalid.
   task automatic push(input logic op, input logic [15:0] ch);
      int seen;
      while ($urandom_range(99) < src_idle) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid   <= 1;
      req_tdata    <= ch;
      req_tuser[0] <= op;
      seen = requests_taken;
      do @(negedge clock); while (requests_taken == seen);
   endtask

   // Source goes quiet until every predicted token has come out.
   task automatic drain();
      req_tvalid <= 0;
      while (sb.expected_tokens.size() != 0) @(negedge clock);
   endtask

   function automatic logic [15:0] ident_char();
      logic [15:0] c;
      do begin
         if ($urandom_range(3) != 0) c = 16'h0061 + 16'($urandom_range(25));
         else c = 16'($urandom);
      end while (lexer_scoreboard::ends_identifier(c));
      return c;
   endfunction

   // delimiter characters: a tiny alphabet so the body often half-matches
   function automatic logic [15:0] delim_char();
      logic [15:0] c;
      do begin
         if ($urandom_range(2) != 0) c = 16'h0041 + 16'($urandom_range(1));
         else c = 16'($urandom);
      end while (c == CH_DQUOTE || c == CH_EOS);
      return c;
   endfunction

   // Quoted text: opening quote, delimiter, closing quote, body, delimiter again.
   // Mostly short delimiters; sometimes empty, full size, one too long, or cut off by EOS.
   task automatic push_text();
      logic [15:0] dlm [DELIM_MAX+1];
      logic [15:0] c;
      int len, body, r;
      bit cut_short;
      r = $urandom_range(99);
      if (r < 8) len = 0;
      else if (r < 14) len = DELIM_MAX;
      else if (r < 19) len = DELIM_MAX + 1;
      else len = $urandom_range(1, 4);
      cut_short = ($urandom_range(19) == 0);
      push(OP_LEX, CH_DQUOTE);
      for (int i = 0; i < len; i++) begin
         dlm[i] = delim_char();
         push(OP_LEX, dlm[i]);
      end
      if (len > DELIM_MAX) return;   // over-long delimiter already flagged
      push(OP_LEX, CH_DQUOTE);
      body = $urandom_range(0, 8);
      repeat (body) begin
         r = $urandom_range(9);
         if (r < 5 && len > 0) c = dlm[$urandom_range(len - 1)];
         else if (r < 8) c = 16'h0061 + 16'($urandom_range(25));
         else c = 16'($urandom);
         if (c == CH_EOS) c = 16'h0078;
         push(OP_LEX, c);
      end
      if (cut_short) push(OP_LEX, CH_EOS);
      else for (int i = 0; i < len; i++) push(OP_LEX, dlm[i]);
   endtask

   task automatic push_ident();
      int n;
      n = $urandom_range(1, 6);
      repeat (n) push(OP_LEX, ident_char());
      case ($urandom_range(11))
         0:  push(OP_LEX, CH_SPACE);
         1:  push(OP_LEX, CH_TAB);
         2:  push(OP_LEX, CH_LF);
         3:  push(OP_LEX, CH_FF);
         4:  push(OP_LEX, CH_NUL);
         5:  push(OP_LEX, CH_SEMI);
         6:  push(OP_LEX, CH_SQUOTE);
         7:  push(OP_LEX, CH_EQUAL);
         8:  push(OP_LEX, CH_POUND);
         9:  push(OP_LEX, CH_EOS);
         default: push_text();    // the quote both ends the name and opens text
      endcase
   endtask

   task automatic push_punct();
      case ($urandom_range(8))
         0: push(OP_LEX, CH_SQUOTE);
         1: push(OP_LEX, CH_EQUAL);
         2: push(OP_LEX, CH_SEMI);
         3: begin
            push(OP_LEX, CH_POUND);
            push(OP_LEX, CH_SEMI);
         end
         4: push(OP_LEX, CH_SPACE);
         5: push(OP_LEX, CH_TAB);
         6: push(OP_LEX, CH_LF);
         7: push(OP_LEX, CH_FF);
         default: push(OP_LEX, CH_NUL);
      endcase
   endtask

   task automatic push_comment();
      logic [15:0] c;
      int n;
      n = $urandom_range(0, 6);
      push(OP_LEX, CH_POUND);
      if ($urandom_range(1)) begin
         push(OP_LEX, CH_SLASH);
         repeat (n) begin
            do c = 16'($urandom); while (c == CH_LF || c == CH_FF || c == CH_EOS);
            push(OP_LEX, c);
         end
         case ($urandom_range(9))
            0:          push(OP_LEX, CH_EOS);
            1, 2, 3, 4: push(OP_LEX, CH_FF);
            default:    push(OP_LEX, CH_LF);
         endcase
      end else begin
         push(OP_LEX, CH_STAR);
         // pounds and stars in the body exercise the close detection
         repeat (n) begin
            case ($urandom_range(3))
               0:       c = CH_POUND;
               1:       c = CH_STAR;
               default: c = 16'($urandom);
            endcase
            if (c == CH_EOS) c = CH_POUND;
            push(OP_LEX, c);
         end
         if ($urandom_range(15) == 0) push(OP_LEX, CH_EOS);
         else begin
            push(OP_LEX, CH_POUND);
            push(OP_LEX, CH_STAR);
         end
      end
   endtask

   task automatic push_bad_control();
      logic [15:0] c;
      push(OP_LEX, CH_POUND);
      if ($urandom_range(3) == 0) push(OP_LEX, CH_EOS);
      else begin
         do c = 16'($urandom);
         while (c == CH_STAR || c == CH_SLASH || c == CH_SEMI || c == CH_EOS);
         push(OP_LEX, c);
      end
   endtask

   // One random fragment of source text; a halted lexer gets a little junk and a restart.
   task automatic push_fragment();
      int r;
      r = $urandom_range(99);
      if (r < 24) push_ident();
      else if (r < 38) push_punct();
      else if (r < 60) push_text();
      else if (r < 72) push_comment();
      else if (r < 76) push_bad_control();
      else if (r < 80) push(OP_LEX, CH_EOS);
      else if (r < 96) repeat ($urandom_range(1, 3)) push(OP_LEX, 16'($urandom));
      else push(OP_RESTART, 16'($urandom));
      if (sb.halted()) begin
         repeat ($urandom_range(2)) push(OP_LEX, 16'($urandom));
         push(OP_RESTART, 16'($urandom));
      end
   endtask

   task automatic run_phase(input int src_pct, input int sink_pct, input int count);
      int target;
      src_idle  = src_pct;
      sink_idle = sink_pct;
      target    = sb.lexed_chars + count;
      while (sb.lexed_chars < target) push_fragment();
      drain();
   endtask

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // directed: every token kind, a block comment, empty and one-char delimiters, errors
      push(OP_RESTART, 16'hFFFF);
      push(OP_LEX, 16'h0061);          // 'a' starts a name
      push(OP_LEX, 16'hFFFF);          // top character code as a name character
      push(OP_LEX, CH_NUL);            // NUL ends the name
      push(OP_LEX, CH_SQUOTE);
      push(OP_LEX, CH_EQUAL);
      push(OP_LEX, CH_SEMI);
      push(OP_LEX, CH_POUND);
      push(OP_LEX, CH_SEMI);           // routine end
      push(OP_LEX, CH_POUND);
      push(OP_LEX, CH_STAR);           // block comment
      push(OP_LEX, CH_POUND);
      push(OP_LEX, CH_POUND);          // run of pounds still arms the close
      push(OP_LEX, CH_STAR);
      push(OP_LEX, CH_DQUOTE);
      push(OP_LEX, CH_DQUOTE);         // empty delimiter: text ends right here
      push(OP_LEX, CH_DQUOTE);
      push(OP_LEX, 16'h0045);          // delimiter "E"
      push(OP_LEX, CH_DQUOTE);
      push(OP_LEX, 16'h0061);          // fills the window, no match yet
      push(OP_LEX, 16'h0045);          // 'a' shifts out, window matches
      push(OP_LEX, 16'h0062);
      push(OP_LEX, CH_POUND);          // ends the name, enters control
      push(OP_LEX, 16'h0021);          // unknown control
      push(OP_LEX, 16'h0078);          // swallowed after the error
      push(OP_RESTART, 16'h0000);
      push(OP_LEX, CH_EOS);            // end of stream from begin
      push(OP_LEX, 16'h007A);          // swallowed after the end
      push(OP_RESTART, 16'h0000);
      drain();

      run_phase(14, 59, 210);
      run_phase(59, 14, 210);
      run_phase(0, 0, 220);

      repeat (SETTLE) @(posedge clock);
      foreach (sb.expected_tokens[i])
         $display("%0t: token never arrived, kind %0d char %h err %0d last %b", $time,
                  sb.expected_tokens[i].kind, sb.expected_tokens[i].chr,
                  sb.expected_tokens[i].err, sb.expected_tokens[i].last);

      $display("Lexed %0d characters across %0d restarts in %0d cycles.",
               sb.lexed_chars, sb.restarts, cycles);
      $display("Checked %0d tokens, %0d of them errors and %0d text ends.",
               sb.tokens_checked, sb.error_tokens, sb.text_ends);
      if (sb.mismatches == 0 && sb.expected_tokens.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/hdtl_pkg.sv
hw/rtl/hdtl_cell.sv
hw/rtl/hdtl_result_fifo.sv
hw/rtl/heredoc_token_lexer.sv
dv/heredoc_token_lexer_test.sv
